[hw/rtl/escaped_frame_deframer_unit_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef ESCAPED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled during rst.
`define EFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, disabled during rst.
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/efd_pkg.sv]
// Package: codes, types and constants of the escaped frame deframer.
`timescale 1ns / 1ps
package efd_pkg;

  localparam logic [7:0] ESC_CODE = 8'h1B;
  localparam logic [7:0] SOF_CODE = 8'h01;
  localparam logic [7:0] EOF_CODE = 8'h04;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CSUM    = 3'd3,
    PH_TRAIL   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SUM    = 3'd1,
    ST_OVERRUN    = 3'd2,
    ST_RESTART    = 3'd3,
    ST_ORPHAN_END = 3'd4
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Classified wire byte, as queued between front and back.
  typedef struct packed {
    logic [7:0] value;
    logic       is_esc;
    logic       is_sof;
    logic       is_eof;
  } tok_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    frame_status;
    logic [7:0] decoded_length;
    logic [7:0] calc_checksum;
    logic [7:0] read_checksum;
  } res_t;

endpackage

[hw/rtl/efd_channel_if.sv]
// Handshake channels: received wire bytes in, deframed words out.
`timescale 1ns / 1ps
interface efd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [2:0] frame_status;
  logic [7:0] decoded_length;
  logic [7:0] calc_checksum;
  logic [7:0] read_checksum;

  modport source (output valid, output kind, output data_byte, output frame_status,
                  output decoded_length, output calc_checksum, output read_checksum,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input frame_status,
                input decoded_length, input calc_checksum, input read_checksum,
                output ready);
endinterface

[hw/rtl/escaped_frame_deframer_unit.sv]
// Top level of the byte-stuffed frame deframer.
// Usage:
//   rx carries one received wire byte per word (valid/ready). deframed carries
//   one result word per handshake: kind 0 is a decoded payload byte, kind 1 an
//   end-of-frame status with decoded length, computed and received checksum.
//   A wire byte produces zero or one result word.
// Timing:
//   Sustained rate is one wire byte per cycle while deframed.ready is high. The
//   front end tags the framing codes and writes the byte into a QUEUE_DEPTH-entry
//   token queue; the back end pops one token per cycle, unless stalled, through
//   a single state update and loads the output register. A result passes the
//   token queue and then the output register before it is valid on deframed.
// Reset (rst, synchronous): the queue empties, the deframer hunts for a frame
//   start, and no result word is pending.
// Stall: while a word is pending and deframed.ready is low the output register
//   holds it and the back end stops; the queue absorbs up to QUEUE_DEPTH more
//   bytes before rx.ready drops.
`timescale 1ns / 1ps
module escaped_frame_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = efd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  efd_byte_if.sink     rx,
  efd_result_if.source deframed
);

  logic          push_valid;
  logic          push_ready;
  efd_pkg::tok_t push_tok;
  logic          pop_valid;
  logic          pop_ready;
  efd_pkg::tok_t pop_tok;

  efd_classify u_classify (
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok)
  );

  efd_tok_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  efd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (pop_valid),
    .tok_ready (pop_ready),
    .tok       (pop_tok),
    .deframed  (deframed)
  );

endmodule

[hw/rtl/efd_classify.sv]
// Front end: accepts wire bytes and tags the framing codes.
`timescale 1ns / 1ps
module efd_classify (
  efd_byte_if.sink    rx,
  output logic        push_valid,
  input  logic        push_ready,
  output efd_pkg::tok_t push_tok
);

  assign rx.ready   = push_ready;
  assign push_valid = rx.valid;

  always_comb begin
    push_tok.value  = rx.rx_byte;
    push_tok.is_esc = (rx.rx_byte == efd_pkg::ESC_CODE);
    push_tok.is_sof = (rx.rx_byte == efd_pkg::SOF_CODE);
    push_tok.is_eof = (rx.rx_byte == efd_pkg::EOF_CODE);
  end

endmodule

[hw/rtl/efd_tok_fifo.sv]
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps
`include "escaped_frame_deframer_unit_macros.svh"
module efd_tok_fifo #(
  parameter int unsigned DEPTH = efd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  efd_pkg::tok_t push_tok,
  output logic          pop_valid,
  input  logic          pop_ready,
  output efd_pkg::tok_t pop_tok
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  efd_pkg::tok_t  slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `EFD_ASSERT_NOW(a_fifo_bound, 1'b1, count <= FULL, "token queue count above depth")

endmodule

[hw/rtl/efd_engine.sv]
// Back end: deframing state machine with a registered output word.
`timescale 1ns / 1ps
`include "escaped_frame_deframer_unit_macros.svh"
module efd_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  output logic            tok_ready,
  input  efd_pkg::tok_t   tok,
  efd_result_if.source    deframed
);

  efd_pkg::phase_t phase, phase_next;
  logic            esc, esc_next;
  logic            skip, skip_next;
  logic [7:0]      raw, raw_next;
  logic [7:0]      cnt, cnt_next;
  logic [7:0]      sum, sum_next;
  logic [7:0]      rcv, rcv_next;
  logic [7:0]      raw_dec;
  logic [7:0]      frame_total;
  logic            ended;

  logic            res_valid;
  efd_pkg::res_t   res;
  logic            out_valid;
  efd_pkg::res_t   out_res;
  logic            can_take;
  logic            tok_pop;

  assign can_take    = !out_valid || deframed.ready;
  assign tok_ready   = can_take;
  assign tok_pop     = tok_valid && can_take;
  assign raw_dec     = (raw != 8'd0) ? raw - 8'd1 : 8'd0;
  assign frame_total = sum + rcv;

  // Next state for one popped word.
  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    skip_next  = skip;
    raw_next   = raw;
    cnt_next   = cnt;
    sum_next   = sum;
    rcv_next   = rcv;
    ended      = 1'b0;
    case (phase)
      efd_pkg::PH_LEN: begin
        raw_next   = tok.value;
        sum_next   = tok.value;
        phase_next = (tok.value == 8'd0) ? efd_pkg::PH_CSUM : efd_pkg::PH_PAYLOAD;
      end
      efd_pkg::PH_PAYLOAD: begin
        raw_next = raw_dec;
        if (skip) begin
          skip_next = 1'b0;
          sum_next  = sum + tok.value;
          cnt_next  = cnt + 8'd1;
        end else if (esc) begin
          esc_next = 1'b0;
          if (tok.is_esc) begin
            sum_next = sum + tok.value;
            cnt_next = cnt + 8'd1;
          end else if (tok.is_sof) begin
            ended      = 1'b1;
            phase_next = efd_pkg::PH_LEN;
            skip_next  = 1'b0;
            raw_next   = 8'd0;
            cnt_next   = 8'd0;
            sum_next   = 8'd0;
            rcv_next   = 8'd0;
          end else if (tok.is_eof) begin
            ended      = 1'b1;
            phase_next = efd_pkg::PH_HUNT;
          end else begin
            skip_next = 1'b1;
          end
        end else if (tok.is_esc) begin
          esc_next = 1'b1;
        end else begin
          sum_next = sum + tok.value;
          cnt_next = cnt + 8'd1;
        end
        // an open escape sequence finishes before the checksum byte
        if (!ended && raw_dec == 8'd0 && !esc_next && !skip_next) begin
          phase_next = efd_pkg::PH_CSUM;
        end
      end
      efd_pkg::PH_CSUM: begin
        rcv_next   = tok.value;
        esc_next   = tok.is_esc;
        phase_next = efd_pkg::PH_TRAIL;
      end
      efd_pkg::PH_TRAIL: begin
        if (esc) begin
          esc_next = 1'b0;
          if (tok.is_eof) begin
            phase_next = efd_pkg::PH_HUNT;
          end else if (tok.is_sof) begin
            phase_next = efd_pkg::PH_LEN;
            skip_next  = 1'b0;
            raw_next   = 8'd0;
            cnt_next   = 8'd0;
            sum_next   = 8'd0;
            rcv_next   = 8'd0;
          end
        end else if (tok.is_esc) begin
          esc_next = 1'b1;
        end
      end
      default: begin
        if (esc) begin
          esc_next = 1'b0;
          if (tok.is_sof) begin
            phase_next = efd_pkg::PH_LEN;
            skip_next  = 1'b0;
            raw_next   = 8'd0;
            cnt_next   = 8'd0;
            sum_next   = 8'd0;
            rcv_next   = 8'd0;
          end else if (tok.is_eof) begin
            phase_next = efd_pkg::PH_HUNT;
          end
        end else if (tok.is_esc) begin
          esc_next = 1'b1;
        end
      end
    endcase
  end

  // Output word for one popped word; status words that close a frame carry the counts so far.
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = efd_pkg::KIND_DATA;
    res.data_byte      = 8'd0;
    res.frame_status   = efd_pkg::ST_OK;
    res.decoded_length = 8'd0;
    res.calc_checksum  = 8'd0;
    res.read_checksum  = 8'd0;
    case (phase)
      efd_pkg::PH_LEN, efd_pkg::PH_CSUM: begin
        res_valid = 1'b0;
      end
      efd_pkg::PH_PAYLOAD: begin
        if (skip || (esc && tok.is_esc) || (!esc && !tok.is_esc)) begin
          res_valid     = 1'b1;
          res.data_byte = tok.value;
        end else if (esc && (tok.is_sof || tok.is_eof)) begin
          res_valid          = 1'b1;
          res.kind           = efd_pkg::KIND_STATUS;
          res.frame_status   = tok.is_sof ? efd_pkg::ST_RESTART : efd_pkg::ST_OVERRUN;
          res.decoded_length = cnt;
          res.calc_checksum  = sum;
          res.read_checksum  = rcv;
        end
      end
      efd_pkg::PH_TRAIL: begin
        if (esc && (tok.is_sof || tok.is_eof)) begin
          res_valid          = 1'b1;
          res.kind           = efd_pkg::KIND_STATUS;
          if (tok.is_sof) begin
            res.frame_status = efd_pkg::ST_RESTART;
          end else begin
            res.frame_status = (frame_total == 8'd0) ? efd_pkg::ST_OK : efd_pkg::ST_BAD_SUM;
          end
          res.decoded_length = cnt;
          res.calc_checksum  = sum;
          res.read_checksum  = rcv;
        end
      end
      default: begin
        if (esc && tok.is_eof) begin
          res_valid        = 1'b1;
          res.kind         = efd_pkg::KIND_STATUS;
          res.frame_status = efd_pkg::ST_ORPHAN_END;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= efd_pkg::PH_HUNT;
      esc   <= 1'b0;
      skip  <= 1'b0;
      raw   <= 8'd0;
      cnt   <= 8'd0;
      sum   <= 8'd0;
      rcv   <= 8'd0;
    end else if (tok_pop) begin
      phase <= phase_next;
      esc   <= esc_next;
      skip  <= skip_next;
      raw   <= raw_next;
      cnt   <= cnt_next;
      sum   <= sum_next;
      rcv   <= rcv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_pop) begin
      out_valid <= res_valid;
    end else if (deframed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && res_valid) begin
      out_res <= res;
    end
  end

  assign deframed.valid          = out_valid;
  assign deframed.kind           = out_res.kind;
  assign deframed.data_byte      = out_res.data_byte;
  assign deframed.frame_status   = out_res.frame_status;
  assign deframed.decoded_length = out_res.decoded_length;
  assign deframed.calc_checksum  = out_res.calc_checksum;
  assign deframed.read_checksum  = out_res.read_checksum;

  `EFD_ASSERT_NOW(a_data_in_payload, tok_pop && res_valid && res.kind == efd_pkg::KIND_DATA,
    phase == efd_pkg::PH_PAYLOAD, "data word outside payload")
  `EFD_ASSERT_NEXT(a_data_counts, tok_pop && res_valid && res.kind == efd_pkg::KIND_DATA,
    cnt == $past(cnt) + 8'd1, "decoded count not advanced by a data word")
  `EFD_ASSERT_NEXT(a_restart_clears,
    tok_pop && res_valid && res.frame_status == efd_pkg::ST_RESTART,
    phase == efd_pkg::PH_LEN && cnt == 8'd0 && rcv == 8'd0, "restart did not reopen frame")
  `EFD_ASSERT_NOW(a_escape_exclusive, 1'b1, !(esc && skip), "escape and skip both set")

endmodule

[tb/sv/tb_escaped_frame_deframer_unit.sv]
// Testbench for the escaped frame deframer: directed table, random frames, in-order checks.
`timescale 1ns / 1ps
module tb_escaped_frame_deframer_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_N = 27;

  typedef struct {
    logic [7:0]    b;
    bit            typed;
    bit            has;
    efd_pkg::res_t r;
  } dir_row_t;

  localparam efd_pkg::res_t NIL = '0;

  logic clk = 1'b0;
  logic rst;

  efd_byte_if   rx_if ();
  efd_result_if out_if ();

  escaped_frame_deframer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_if),
    .deframed (out_if)
  );

  always #1 clk = ~clk;

  // Deframer state as seen by the testbench
  efd_pkg::phase_t ph;
  bit              esc_open;
  bit              skip_next;
  logic [7:0]      raw_left;
  logic [7:0]      dec_cnt;
  logic [7:0]      sum_acc;
  logic [7:0]      rcv_csum;

  efd_pkg::res_t deframed_due [$];
  dir_row_t      dir_tab [DIR_N];
  int            src_gap_pct;
  int            snk_stall_pct;
  int            fail_cnt = 0;
  int            cycle_cnt = 0;

  function automatic void open_frame();
    ph        = efd_pkg::PH_LEN;
    esc_open  = 1'b0;
    skip_next = 1'b0;
    raw_left  = 8'h00;
    dec_cnt   = 8'h00;
    sum_acc   = 8'h00;
    rcv_csum  = 8'h00;
  endfunction

  function automatic void take_data(input logic [7:0] b, output efd_pkg::res_t r);
    sum_acc = sum_acc + b;
    dec_cnt = dec_cnt + 8'd1;
    r = '0;
    r.kind = efd_pkg::KIND_DATA;
    r.data_byte = b;
    r.frame_status = efd_pkg::ST_OK;
  endfunction

  function automatic void take_status(input efd_pkg::status_t st, input bit counts,
                                      output efd_pkg::res_t r);
    r = '0;
    r.kind = efd_pkg::KIND_STATUS;
    r.frame_status = st;
    if (counts) begin
      r.decoded_length = dec_cnt;
      r.calc_checksum  = sum_acc;
      r.read_checksum  = rcv_csum;
    end
  endfunction

  // Advances the state by one wire byte; returns 1 when a word is due.
  function automatic bit deframe_byte(input logic [7:0] b, output efd_pkg::res_t r);
    bit hit;
    bit left_payload;
    hit = 1'b0;
    left_payload = 1'b0;
    r = '0;
    case (ph)
      efd_pkg::PH_LEN: begin
        raw_left = b;
        sum_acc  = b;
        ph = (b == 8'h00) ? efd_pkg::PH_CSUM : efd_pkg::PH_PAYLOAD;
      end
      efd_pkg::PH_PAYLOAD: begin
        if (raw_left != 8'h00) raw_left = raw_left - 8'd1;
        if (skip_next) begin
          skip_next = 1'b0;
          take_data(b, r);
          hit = 1'b1;
        end else if (esc_open) begin
          esc_open = 1'b0;
          if (b == efd_pkg::ESC_CODE) begin
            take_data(b, r);
            hit = 1'b1;
          end else if (b == efd_pkg::SOF_CODE) begin
            take_status(efd_pkg::ST_RESTART, 1'b1, r);
            hit = 1'b1;
            open_frame();
            left_payload = 1'b1;
          end else if (b == efd_pkg::EOF_CODE) begin
            take_status(efd_pkg::ST_OVERRUN, 1'b1, r);
            hit = 1'b1;
            ph = efd_pkg::PH_HUNT;
            left_payload = 1'b1;
          end else begin
            skip_next = 1'b1;
          end
        end else if (b == efd_pkg::ESC_CODE) begin
          esc_open = 1'b1;
        end else begin
          take_data(b, r);
          hit = 1'b1;
        end
        // an open escape finishes before the checksum byte
        if (!left_payload && raw_left == 8'h00 && !esc_open && !skip_next) begin
          ph = efd_pkg::PH_CSUM;
        end
      end
      efd_pkg::PH_CSUM: begin
        rcv_csum = b;
        esc_open = (b == efd_pkg::ESC_CODE);
        ph = efd_pkg::PH_TRAIL;
      end
      efd_pkg::PH_TRAIL: begin
        if (esc_open) begin
          esc_open = 1'b0;
          if (b == efd_pkg::EOF_CODE) begin
            take_status((sum_acc + rcv_csum == 8'h00) ? efd_pkg::ST_OK : efd_pkg::ST_BAD_SUM,
                        1'b1, r);
            hit = 1'b1;
            ph = efd_pkg::PH_HUNT;
          end else if (b == efd_pkg::SOF_CODE) begin
            take_status(efd_pkg::ST_RESTART, 1'b1, r);
            hit = 1'b1;
            open_frame();
          end
        end else if (b == efd_pkg::ESC_CODE) begin
          esc_open = 1'b1;
        end
      end
      default: begin
        if (esc_open) begin
          esc_open = 1'b0;
          if (b == efd_pkg::SOF_CODE) begin
            open_frame();
          end else if (b == efd_pkg::EOF_CODE) begin
            take_status(efd_pkg::ST_ORPHAN_END, 1'b0, r);
            hit = 1'b1;
            ph = efd_pkg::PH_HUNT;
          end
        end else if (b == efd_pkg::ESC_CODE) begin
          esc_open = 1'b1;
        end
      end
    endcase
    return hit;
  endfunction

  // Presents one wire byte and returns in the step where it was taken.
  task automatic send_wire_byte(input logic [7:0] b);
    if ($urandom_range(99) < src_gap_pct) begin
      rx_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  task automatic hold_until_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (deframed_due.size() != 0);
  endtask

  task automatic run_random_frames(input int n_items);
    logic [7:0] wire_q [$];
    logic [7:0] body [$];
    logic [7:0] len, sum, csum, d, x;
    int n_dec, cut, e, sent;
    bit hdr_open;
    efd_pkg::res_t r;
    sent = 0;
    hdr_open = 1'b0;
    while (sent < n_items) begin
      wire_q.delete();
      body.delete();
      if ($urandom_range(99) < 8) begin
        // noise between frames, biased toward the framing codes
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(3))
            0: d = efd_pkg::ESC_CODE;
            1: d = efd_pkg::SOF_CODE;
            2: d = efd_pkg::EOF_CODE;
            default: d = 8'($urandom_range(255));
          endcase
          wire_q = {wire_q, d};
        end
      end else begin
        n_dec = ($urandom_range(39) == 0) ? $urandom_range(50, 75) : $urandom_range(0, 8);
        sum = 8'h00;
        repeat (n_dec) begin
          d = ($urandom_range(5) == 0) ? efd_pkg::ESC_CODE : 8'($urandom_range(255));
          sum = sum + d;
          if ($urandom_range(3) == 0) begin
            x = 8'($urandom_range(255));
            if (x == efd_pkg::ESC_CODE || x == efd_pkg::SOF_CODE || x == efd_pkg::EOF_CODE) begin
              x = x ^ 8'h40;
            end
            body = {body, efd_pkg::ESC_CODE, x, d};
          end else if (d == efd_pkg::ESC_CODE) begin
            body = {body, efd_pkg::ESC_CODE, efd_pkg::ESC_CODE};
          end else begin
            body = {body, d};
          end
        end
        len = 8'(body.size());
        if ($urandom_range(9) == 0) len = len + 8'($urandom_range(4)) - 8'd2;
        csum = 8'h00 - len - sum;
        if ($urandom_range(7) == 0) csum = 8'($urandom_range(255));
        if (!hdr_open) begin
          wire_q = {wire_q, efd_pkg::ESC_CODE, efd_pkg::SOF_CODE};
        end
        hdr_open = 1'b0;
        wire_q = {wire_q, len};
        e = $urandom_range(99);
        if (e < 16) begin
          // cut short by an end marker (overrun) or a new start
          cut = $urandom_range(body.size());
          for (int i = 0; i < cut; i++) wire_q = {wire_q, body[i]};
          if (cut == body.size()) wire_q = {wire_q, csum};
          wire_q = {wire_q, efd_pkg::ESC_CODE};
          wire_q = {wire_q, (e < 8) ? efd_pkg::EOF_CODE : efd_pkg::SOF_CODE};
          hdr_open = (e >= 8);
        end else begin
          foreach (body[i]) wire_q = {wire_q, body[i]};
          wire_q = {wire_q, csum};
          if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              d = 8'($urandom_range(255));
              wire_q = {wire_q, d};
              if (d == efd_pkg::ESC_CODE) wire_q = {wire_q, efd_pkg::ESC_CODE};
            end
          end
          if ($urandom_range(19) != 0) begin
            wire_q = {wire_q, efd_pkg::ESC_CODE, efd_pkg::EOF_CODE};
          end
        end
        sent += wire_q.size();
      end
      foreach (wire_q[i]) begin
        send_wire_byte(wire_q[i]);
        if (deframe_byte(wire_q[i], r)) deframed_due = {deframed_due, r};
      end
    end
  endtask

  always @(posedge clk) begin : deframed_check
    efd_pkg::res_t want;
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    if (!rst && out_if.valid && out_if.ready) begin
      if (deframed_due.size() == 0) begin
        $error("unexpected deframed word: kind %0d data %h status %0d",
               out_if.kind, out_if.data_byte, out_if.frame_status);
        fail_cnt++;
      end else begin
        want = deframed_due[0];
        deframed_due.delete(0);
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_if.kind);
          fail_cnt++;
        end
        if (out_if.data_byte !== want.data_byte) begin
          $error("data_byte: expected %h, actual %h", want.data_byte, out_if.data_byte);
          fail_cnt++;
        end
        if (out_if.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, actual %0d", want.frame_status,
                 out_if.frame_status);
          fail_cnt++;
        end
        if (out_if.decoded_length !== want.decoded_length) begin
          $error("decoded_length: expected %0d, actual %0d", want.decoded_length,
                 out_if.decoded_length);
          fail_cnt++;
        end
        if (out_if.calc_checksum !== want.calc_checksum) begin
          $error("calc_checksum: expected %h, actual %h", want.calc_checksum,
                 out_if.calc_checksum);
          fail_cnt++;
        end
        if (out_if.read_checksum !== want.read_checksum) begin
          $error("read_checksum: expected %h, actual %h", want.read_checksum,
                 out_if.read_checksum);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_escaped_frame_deframer_unit: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    bit            hit;
    efd_pkg::res_t r;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    src_gap_pct   = 17;
    snk_stall_pct = 58;
    open_frame();
    ph = efd_pkg::PH_HUNT;

    dir_tab = '{
      // end marker while hunting
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::EOF_CODE, 1'b1, 1'b1,
        '{efd_pkg::KIND_STATUS, 8'h00, efd_pkg::ST_ORPHAN_END, 8'h00, 8'h00, 8'h00}},
      // empty frame, checksum byte is ESC and opens the end pair
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::SOF_CODE, 1'b1, 1'b0, NIL},
      '{8'h00,             1'b0, 1'b0, NIL},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::EOF_CODE, 1'b1, 1'b1,
        '{efd_pkg::KIND_STATUS, 8'h00, efd_pkg::ST_BAD_SUM, 8'h00, 8'h00, 8'h1B}},
      // good frame: FF, then ESC x ESC taken literally, trailing byte ignored
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::SOF_CODE, 1'b0, 1'b0, NIL},
      '{8'h04,             1'b0, 1'b0, NIL},
      '{8'hFF,             1'b1, 1'b1,
        '{efd_pkg::KIND_DATA, 8'hFF, efd_pkg::ST_OK, 8'h00, 8'h00, 8'h00}},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{8'h55,             1'b0, 1'b0, NIL},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{8'hE2,             1'b0, 1'b0, NIL},
      '{8'h77,             1'b1, 1'b0, NIL},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::EOF_CODE, 1'b0, 1'b0, NIL},
      // start inside the payload
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::SOF_CODE, 1'b0, 1'b0, NIL},
      '{8'h02,             1'b0, 1'b0, NIL},
      '{8'h00,             1'b0, 1'b0, NIL},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::SOF_CODE, 1'b1, 1'b1,
        '{efd_pkg::KIND_STATUS, 8'h00, efd_pkg::ST_RESTART, 8'h01, 8'h02, 8'h00}},
      // escape open at the payload end, then end marker
      '{8'h01,             1'b0, 1'b0, NIL},
      '{efd_pkg::ESC_CODE, 1'b0, 1'b0, NIL},
      '{efd_pkg::EOF_CODE, 1'b1, 1'b1,
        '{efd_pkg::KIND_STATUS, 8'h00, efd_pkg::ST_OVERRUN, 8'h00, 8'h01, 8'h00}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_wire_byte(dir_tab[i].b);
      hit = deframe_byte(dir_tab[i].b, r);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].has) deframed_due = {deframed_due, dir_tab[i].r};
      end else if (hit) begin
        deframed_due = {deframed_due, r};
      end
    end
    hold_until_drained();

    run_random_frames(150);
    hold_until_drained();

    src_gap_pct   = 58;
    snk_stall_pct = 17;
    run_random_frames(150);
    hold_until_drained();

    src_gap_pct   = 0;
    snk_stall_pct = 0;
    run_random_frames(150);
    hold_until_drained();

    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_escaped_frame_deframer_unit: PASS");
    end else begin
      $display("tb_escaped_frame_deframer_unit: FAIL");
    end
    $finish;
  end

endmodule

[escaped_frame_deframer_unit.f]
+incdir+hw/rtl
hw/rtl/efd_pkg.sv
hw/rtl/efd_channel_if.sv
hw/rtl/efd_classify.sv
hw/rtl/efd_tok_fifo.sv
hw/rtl/efd_engine.sv
hw/rtl/escaped_frame_deframer_unit.sv
tb/sv/tb_escaped_frame_deframer_unit.sv
